// ===== design/sorted_priority_queue_defines.svh =====
// Assertion macros used by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_POP    = 2'd2;
  localparam kind_t KIND_READ   = 2'd3;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NOTFOUND = 2'd1;
  localparam status_t STATUS_FULL     = 2'd2;
  localparam status_t STATUS_EMPTY    = 2'd3;

  localparam int POS_BITS    = 4;
  localparam int PRI_BITS    = 8;
  localparam int HDL_BITS    = 16;
  localparam int COUNT_BITS  = 5;

endpackage

`default_nettype wire

// ===== design/spq_in_if.sv =====
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [PRI_BITS-1:0] priority_req;
  logic [HDL_BITS-1:0] handle;
  logic [POS_BITS-1:0] position;

  modport source (output valid, kind, priority_req, handle, position, input ready);
  modport sink   (input valid, kind, priority_req, handle, position, output ready);
endinterface

`default_nettype wire

// ===== design/spq_out_if.sv =====
`default_nettype none

interface spq_out_if import spq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [HDL_BITS-1:0]   out_handle;
  logic [PRI_BITS-1:0]   out_priority;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  head_valid;
  logic [HDL_BITS-1:0]   head_handle;
  logic [PRI_BITS-1:0]   head_priority;

  modport source (output valid, status, out_handle, out_priority, entry_count,
                  head_valid, head_handle, head_priority, input ready);
  modport sink   (input valid, status, out_handle, out_priority, entry_count,
                  head_valid, head_handle, head_priority, output ready);
endinterface

`default_nettype wire

// ===== design/spq_slot_ram.sv =====
`default_nettype none

module spq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Channel   Role    Carries
// in_ch     sink    kind, priority_req, handle, position
// out_ch    source  status, popped/removed/read entry, count, head entry
//
// The entries live in a single-port-read RAM walked by a small sequencer.
// A read whose index is out of range, and an insert into a full queue,
// skip the walk. An insert walks from the tail one entry at a time until
// the new entry fits, and remove and pop walk over every held entry.
// Each walk step is a RAM read and a compare. Ready returns with the result.
// Reset empties the queue at once; the RAM contents are not cleared.
// A result waits in the output register while the next item is taken in;
// if it is still waiting when that item finishes, the sequencer holds and
// takes no new item until the waiting result leaves.
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH         = 16,
  parameter int HANDLE_BITS   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = PRIORITY_BITS + HANDLE_BITS;
  localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_CMP  = 4'd2;
  localparam logic [3:0] S_WALK_RD  = 4'd3;
  localparam logic [3:0] S_WALK_CMP = 4'd4;
  localparam logic [3:0] S_POS_RD   = 4'd5;
  localparam logic [3:0] S_RD_CMP   = 4'd6;
  localparam logic [3:0] S_HEAD_RD  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]               state_r;
  logic [CW-1:0]            occ_r;
  logic [CW-1:0]            idx_r;
  kind_t                    kind_r;
  logic [PRIORITY_BITS-1:0] pri_r;
  logic [HANDLE_BITS-1:0]   hdl_r;
  logic                     found_r;
  status_t                  status_r;
  logic [PRIORITY_BITS-1:0] res_pri_r;
  logic [HANDLE_BITS-1:0]   res_hdl_r;
  logic                     out_valid_r;

  logic                     in_fire;
  logic                     pos_ok;
  logic [CW-1:0]            idx_m1;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [WW-1:0]            ram_rdata;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [HANDLE_BITS-1:0]   rd_hdl;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos_ok      = XW'(in_ch.position) < XW'(occ_r);
  assign idx_m1      = idx_r - 1'b1;
  assign rd_pri      = ram_rdata[WW-1:HANDLE_BITS];
  assign rd_hdl      = ram_rdata[HANDLE_BITS-1:0];

  spq_slot_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port control. Insert walks from the tail toward the head, moving
  // each lower-priority entry down one slot until the new entry fits.
  // Remove and pop walk from the head; once the victim is found, every
  // later entry moves up one slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {pri_r, hdl_r};
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_m1[AW-1:0];
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if (rd_pri < pri_r) begin
          ram_wdata = ram_rdata;
        end
      end
      S_WALK_RD: begin
        if (idx_r != occ_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
        end
      end
      S_WALK_CMP: begin
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[AW-1:0];
          ram_wdata = ram_rdata;
        end
      end
      S_POS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
      end
      S_HEAD_RD: begin
        ram_re = (occ_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r    <= in_ch.kind;
            pri_r     <= PRIORITY_BITS'(in_ch.priority_req);
            hdl_r     <= HANDLE_BITS'(in_ch.handle);
            found_r   <= 1'b0;
            res_pri_r <= '0;
            res_hdl_r <= '0;
            unique case (in_ch.kind)
              KIND_INSERT: begin
                if (occ_r == CW'(DEPTH)) begin
                  status_r <= STATUS_FULL;
                  state_r  <= S_HEAD_RD;
                end else begin
                  status_r <= STATUS_OK;
                  idx_r    <= occ_r;
                  state_r  <= S_INS_RD;
                end
              end
              KIND_REMOVE, KIND_POP: begin
                status_r <= STATUS_OK;
                idx_r    <= '0;
                state_r  <= S_WALK_RD;
              end
              KIND_READ: begin
                if (pos_ok) begin
                  status_r <= STATUS_OK;
                  idx_r    <= CW'(in_ch.position);
                  state_r  <= S_POS_RD;
                end else begin
                  status_r <= STATUS_NOTFOUND;
                  state_r  <= S_HEAD_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_r == '0) begin
            occ_r   <= occ_r + 1'b1;
            state_r <= S_HEAD_RD;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_pri >= pri_r) begin
            occ_r   <= occ_r + 1'b1;
            state_r <= S_HEAD_RD;
          end else begin
            idx_r   <= idx_m1;
            state_r <= S_INS_RD;
          end
        end
        S_WALK_RD: begin
          if (idx_r == occ_r) begin
            if (found_r) begin
              occ_r <= occ_r - 1'b1;
            end else if (kind_r == KIND_POP) begin
              status_r <= STATUS_EMPTY;
            end else begin
              status_r <= STATUS_NOTFOUND;
            end
            state_r <= S_HEAD_RD;
          end else begin
            state_r <= S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          // A pop takes the head, which the walk reaches first.
          if (!found_r && (kind_r == KIND_POP || rd_hdl == hdl_r)) begin
            found_r   <= 1'b1;
            res_pri_r <= rd_pri;
            res_hdl_r <= rd_hdl;
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_WALK_RD;
        end
        S_POS_RD: begin
          state_r <= S_RD_CMP;
        end
        S_RD_CMP: begin
          res_pri_r <= rd_pri;
          res_hdl_r <= rd_hdl;
          state_r   <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload; the head comes from the slot zero read issued just before.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_ch.status       <= status_r;
      out_ch.out_handle   <= HDL_BITS'(res_hdl_r);
      out_ch.out_priority <= PRI_BITS'(res_pri_r);
      out_ch.entry_count  <= COUNT_BITS'(occ_r);
      out_ch.head_valid   <= (occ_r != '0);
      if (occ_r != '0) begin
        out_ch.head_handle   <= HDL_BITS'(rd_hdl);
        out_ch.head_priority <= PRI_BITS'(rd_pri);
      end else begin
        out_ch.head_handle   <= '0;
        out_ch.head_priority <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

  `SPQ_ASSERT(a_occ_bound, occ_r <= CW'(DEPTH), "occupancy above depth")
  `SPQ_ASSERT_NEXT(a_accept_busy, in_fire, state_r != S_IDLE, "sequencer idle after accept")
  `SPQ_ASSERT(a_we_state, ram_we |-> (state_r == S_INS_RD || state_r == S_INS_CMP || state_r == S_WALK_CMP), "RAM write outside a shift")
  `SPQ_ASSERT_NEXT(a_occ_step, 1'b1, (occ_r == $past(occ_r) || occ_r == $past(occ_r) + 1'b1 || occ_r + 1'b1 == $past(occ_r)), "occupancy moved by more than one")

endmodule

`default_nettype wire
